### hw/rtl/kdcd_pkg.sv
// ----------------------------------------------------------------------------
// kdcd_pkg
// Shared types and constants for the key debounce and click detector.
// ----------------------------------------------------------------------------
package kdcd_pkg;

    localparam int CNT_W   = 8;
    localparam int ALM_W   = 3;
    localparam int PHASE_W = 2;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [CNT_W-1:0] THRESH_RST = 8'd3;
    localparam logic [CNT_W-1:0] WINDOW_RST = 8'd30;
    localparam logic [ALM_W-1:0] ALM_RST    = 3'd7;

    // register index, paddr[3:2]
    localparam logic [1:0] REG_THRESH = 2'd0;
    localparam logic [1:0] REG_WINDOW = 2'd1;
    localparam logic [1:0] REG_ALM    = 2'd2;

    // click phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_OPEN   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SECOND = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] thresh;
        logic [CNT_W-1:0] window;
        logic [ALM_W-1:0] alm;
    } kdcd_cfg_t;

    typedef struct packed {
        logic dbl;
        logic click;
        logic up;
        logic down;
    } kdcd_evt_t;

endpackage

### hw/rtl/kdcd_lane.sv
// ----------------------------------------------------------------------------
// kdcd_lane
// One key: debounce counter, stable level and double-click window tracker.
// ----------------------------------------------------------------------------
module kdcd_lane #(
    parameter int KEY_IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kdcd_pkg::kdcd_cfg_t cfg,
    input  logic              pin,
    input  logic              step,
    output kdcd_pkg::kdcd_evt_t evt
);
    import kdcd_pkg::*;

    logic               stable_reg, stable_next;
    logic [CNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   wcnt_reg, wcnt_next;
    logic               low_active;
    logic               pressed;
    logic [CNT_W-1:0]   dcnt_inc;
    logic [CNT_W-1:0]   wcnt_inc;
    logic               flip;
    logic [PHASE_W-1:0] phase_mid;
    logic [CNT_W-1:0]   wcnt_mid;

    generate
        if (KEY_IDX < ALM_W)
        begin : g_alm
            assign low_active = cfg.alm[KEY_IDX];
        end
        else
        begin : g_no_alm
            assign low_active = 1'b0;
        end
    endgenerate

    assign pressed  = pin ^ low_active;
    assign dcnt_inc = dcnt_reg + 1'b1;
    assign flip     = (pressed != stable_reg) && (dcnt_inc >= cfg.thresh);

    always_comb
    begin
        evt         = '0;
        dcnt_next   = '0;
        stable_next = stable_reg;
        phase_mid   = phase_reg;
        wcnt_mid    = wcnt_reg;
        wcnt_inc    = '0;

        if (pressed != stable_reg)
        begin
            if (flip)
            begin
                stable_next = pressed;
                evt.down    = pressed;
                evt.up      = !pressed;
                if (!pressed)
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            phase_mid = PH_OPEN;
                            wcnt_mid  = '0;
                        end
                        PH_OPEN:   phase_mid = PH_SECOND;
                        default:   phase_mid = phase_reg;
                    endcase
                end
            end
            else
            begin
                dcnt_next = dcnt_inc;
            end
        end

        phase_next = phase_mid;
        wcnt_next  = wcnt_mid;
        wcnt_inc   = wcnt_mid + 1'b1;
        case (phase_mid)
            PH_OPEN:
            begin
                if (!stable_next)
                begin
                    wcnt_next = wcnt_inc;
                    if (wcnt_inc >= cfg.window)
                    begin
                        phase_next = PH_IDLE;
                        wcnt_next  = '0;
                        evt.click  = 1'b1;
                    end
                end
            end
            PH_SECOND:
            begin
                phase_next = PH_IDLE;
                wcnt_next  = '0;
                evt.dbl    = 1'b1;
            end
            default:
            begin
                phase_next = phase_mid;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            dcnt_reg   <= '0;
            phase_reg  <= PH_IDLE;
            wcnt_reg   <= '0;
        end
        else if (step)
        begin
            stable_reg <= stable_next;
            dcnt_reg   <= dcnt_next;
            phase_reg  <= phase_next;
            wcnt_reg   <= wcnt_next;
        end
    end

endmodule

### hw/rtl/kdcd_merge.sv
// ----------------------------------------------------------------------------
// kdcd_merge
// Gathers the lane events into event masks and holds the output request.
// ----------------------------------------------------------------------------
module kdcd_merge #(
    parameter int KEY_COUNT = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kdcd_pkg::kdcd_evt_t [KEY_COUNT-1:0] evt,
    input  logic                                step,
    input  logic                                m_axis_tready,
    output logic                                m_axis_tvalid,
    output logic [((4*KEY_COUNT+7)/8)*8-1:0]    m_axis_tdata
);
    import kdcd_pkg::*;

    localparam int OUT_W = ((4*KEY_COUNT+7)/8)*8;

    logic [KEY_COUNT-1:0] downs, ups, clicks, dbls;
    logic                 valid_reg, valid_next;
    logic [OUT_W-1:0]     data_reg;

    always_comb
    begin
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            downs[k]  = evt[k].down;
            ups[k]    = evt[k].up;
            clicks[k] = evt[k].click;
            dbls[k]   = evt[k].dbl;
        end
    end

    assign valid_next = step || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            data_reg <= OUT_W'({dbls, clicks, ups, downs});
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

### hw/rtl/key_debounce_click_detector_core.sv
// ----------------------------------------------------------------------------
// key_debounce_click_detector_core
// Per-key debounce with down/up, single-click and double-click event masks.
// ----------------------------------------------------------------------------
//  channel   dir   handshake                 payload
//  s_axis    in    tvalid / tready           pin_levels
//  m_axis    out   tvalid / tready           down, up, click, double masks
//  apb       in    psel, penable, pready     threshold, window, active-low
//
//  One scan tick per cycle unless a held output stalls input; a result appears the cycle after its request.
//  Every key is an independent lane updated in the accepting cycle.
//  The single output register stalls input only while it is full and held.
//  Reset clears all key state and loads the register defaults.
// ----------------------------------------------------------------------------
module key_debounce_click_detector_core #(
    parameter int KEY_COUNT = 3
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // pin_levels [KEY_COUNT-1:0]
    input  logic [((KEY_COUNT+7)/8)*8-1:0]         s_axis_tdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // down_events, up_events, click_events, double_click_events (KEY_COUNT each)
    output logic [((4*KEY_COUNT+7)/8)*8-1:0]       m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [kdcd_pkg::APB_AW-1:0]            paddr,
    input  logic [kdcd_pkg::APB_DW-1:0]            pwdata,
    output logic [kdcd_pkg::APB_DW-1:0]            prdata,
    output logic                                   pready
);
    import kdcd_pkg::*;

    logic [CNT_W-1:0]    thresh_reg, thresh_next;
    logic [CNT_W-1:0]    window_reg, window_next;
    logic [ALM_W-1:0]    alm_reg, alm_next;
    logic                wr_en;
    logic [1:0]          reg_idx;
    logic                step;
    kdcd_cfg_t           cfg;
    kdcd_evt_t [KEY_COUNT-1:0] evt;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        thresh_next = thresh_reg;
        window_next = window_reg;
        alm_next    = alm_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_THRESH: thresh_next = pwdata[CNT_W-1:0];
                REG_WINDOW: window_next = pwdata[CNT_W-1:0];
                REG_ALM:    alm_next    = pwdata[ALM_W-1:0];
                default:    thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RST;
            window_reg <= WINDOW_RST;
            alm_reg    <= ALM_RST;
        end
        else
        begin
            thresh_reg <= thresh_next;
            window_reg <= window_next;
            alm_reg    <= alm_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_THRESH: prdata = APB_DW'(thresh_reg);
            REG_WINDOW: prdata = APB_DW'(window_reg);
            REG_ALM:    prdata = APB_DW'(alm_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.thresh = thresh_reg;
    assign cfg.window = window_reg;
    assign cfg.alm    = alm_reg;

    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    generate
        for (genvar k = 0; k < KEY_COUNT; k++)
        begin : g_lane
            kdcd_lane #(
                .KEY_IDX (k)
            ) u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .cfg   (cfg),
                .pin   (s_axis_tdata[k]),
                .step  (step),
                .evt   (evt[k])
            );
        end
    endgenerate

    kdcd_merge #(
        .KEY_COUNT (KEY_COUNT)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt           (evt),
        .step          (step),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### hw/rtl/kdcd_checker.sv
// ----------------------------------------------------------------------------
// kdcd_checker
// Port-level checks for the key debounce and click detector.
// ----------------------------------------------------------------------------
module kdcd_checker #(
    parameter int KEY_COUNT = 3
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tready,
    input logic [((4*KEY_COUNT+7)/8)*8-1:0]  m_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready
);
    localparam int K = KEY_COUNT;

    logic [K-1:0] downs, ups, clicks, dbls;

    assign downs  = m_axis_tdata[K-1:0];
    assign ups    = m_axis_tdata[2*K-1:K];
    assign clicks = m_axis_tdata[3*K-1:2*K];
    assign dbls   = m_axis_tdata[4*K-1:3*K];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output request changed while stalled");

    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_down_up: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (downs & ups) == '0)
        else $error("down and up on the same key in one tick");

    a_dbl_up: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (dbls & ~ups) == '0)
        else $error("double click without a release");

    a_click_down: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (clicks & downs) == '0)
        else $error("click while key goes down");

endmodule

bind key_debounce_click_detector_core kdcd_checker #(
    .KEY_COUNT (KEY_COUNT)
) u_kdcd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
